// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tile plane pixel fetch block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TPF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`define TPF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define TPF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define TPF_ASSERT(lbl, clk, rst_n, prop)
`define TPF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TPF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/tpf_pkg.sv -----
// ---------------------------------------------------------------------------
// Tile plane pixel fetch package
// Types, constants and register indexes shared by the plane fetch modules.
// ---------------------------------------------------------------------------
package tpf_pkg;

  // Memory depths must be powers of two.
  localparam int unsigned VRAM_WORDS  = 32768;
  localparam int unsigned VSRAM_WORDS = 64;
  localparam int unsigned VRAM_AW     = $clog2(VRAM_WORDS);
  localparam int unsigned VSRAM_AW    = $clog2(VSRAM_WORDS);

  localparam int unsigned ADDR_W     = 15;
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned VS_W       = 11;
  localparam int unsigned HS_W       = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned Q_PTR_W  = $clog2(QDEPTH);
  localparam int unsigned Q_CNT_W  = $clog2(QDEPTH + 1);

  localparam logic [ADDR_W-1:0] NT_WIDE_CLR = 15'h0400;

  localparam logic [1:0] PLANE_A   = 2'd0;
  localparam logic [1:0] PLANE_B   = 2'd1;
  localparam logic [1:0] PLANE_WIN = 2'd2;

  localparam logic [1:0] HS_WHOLE = 2'd0;
  localparam logic [1:0] HS_EIGHT = 2'd1;
  localparam logic [1:0] HS_CELL  = 2'd2;
  localparam logic [1:0] HS_LINE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_KIND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HS_BASE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HS_MODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VS_COL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NT_BASE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NT_SIZE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_BASE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_MODE  = 3'd7;

  typedef enum logic [1:0] {
    CMD_VRAM_WR  = 2'd0,
    CMD_VSRAM_WR = 2'd1,
    CMD_LINE     = 2'd2,
    CMD_PIXEL    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ISSUE   = 3'b001,
    ST_HSCROLL = 3'b010,
    ST_ATTR    = 3'b100
  } back_state_e;

  typedef struct packed {
    logic [1:0]        plane_kind;
    logic [ADDR_W-1:0] hs_base;
    logic [1:0]        hs_mode;
    logic              vs_col;
    logic [ADDR_W-1:0] nt_base;
    logic [3:0]        nt_size;
    logic [ADDR_W-1:0] pat_base;
    logic [1:0]        disp_mode;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] mem_address;
    logic [DATA_W-1:0] mem_data;
    logic [8:0]        pixel_x;
    logic [8:0]        line_y;
    logic              field_bit;
  } in_req_t;

  typedef struct packed {
    logic [5:0] color_index;
    logic       priority_bit;
  } out_res_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [8:0]        x;
    logic [8:0]        y;
    logic              fld;
    logic [VS_W-1:0]   vscroll;
  } job_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
  } qstat_t;

endpackage

// ----- hw/rtl/tile_plane_pixel_fetch_top.sv -----
// ---------------------------------------------------------------------------
// Tile plane pixel fetch
// Tile-map background plane: video and scroll memory writes, line start,
// and per-pixel colour and priority lookup.
// ---------------------------------------------------------------------------
// Requests enter through push/full and carry a command: write a video word,
// write a vertical scroll word, start a line, or fetch one pixel. Only pixel
// requests produce a result; it appears at out_res_o while empty is low and
// leaves on pop. Results come back in request order.
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must write them only while the block is idle, as the
// block itself does not enforce this. The back end issues the two dependent
// reads of a pixel (name table entry, then pattern word) on the single video
// memory port before it takes the next request; a line start on a non-window
// plane also passes through a horizontal scroll load state. A four-entry
// queue parts front and back; when the result queue fills the back end holds
// pixels, and full rises once the command queue backs up. Reset clears the
// configuration, both scroll latches and all queues; the memories are not
// cleared and must be written before they are read.
// ---------------------------------------------------------------------------
module tile_plane_pixel_fetch_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tpf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tpf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               push,
  output logic                               full,
  input  tpf_pkg::in_req_t                   in_req_i,
  output logic                               empty,
  input  logic                               pop,
  output tpf_pkg::out_res_t                  out_res_o
);
  import tpf_pkg::*;

  cfg_t     cfg_q, cfg_d;
  logic     q_push, q_pop, r_push;
  job_t     q_job_in, q_job_out;
  qstat_t   qstat, rstat;
  out_res_t r_res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PLANE_KIND: cfg_d.plane_kind = cfg_data_i[1:0];
        CFG_HS_BASE:    cfg_d.hs_base    = cfg_data_i;
        CFG_HS_MODE:    cfg_d.hs_mode    = cfg_data_i[1:0];
        CFG_VS_COL:     cfg_d.vs_col     = cfg_data_i[0];
        CFG_NT_BASE:    cfg_d.nt_base    = cfg_data_i;
        CFG_NT_SIZE:    cfg_d.nt_size    = cfg_data_i[3:0];
        CFG_PAT_BASE:   cfg_d.pat_base   = cfg_data_i;
        CFG_DISP_MODE:  cfg_d.disp_mode  = cfg_data_i[1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tpf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_push_i(push),
    .in_full_o(full),
    .in_req_i (in_req_i),
    .qstat_i  (qstat),
    .q_push_o (q_push),
    .q_job_o  (q_job_in)
  );

  tpf_cmd_queue u_cmd_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .job_i (q_job_in),
    .pop_i (q_pop),
    .job_o (q_job_out),
    .stat_o(qstat)
  );

  tpf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .q_job_i (q_job_out),
    .qstat_i (qstat),
    .q_pop_o (q_pop),
    .rstat_i (rstat),
    .r_push_o(r_push),
    .r_res_o (r_res)
  );

  tpf_res_queue u_res_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(r_push),
    .res_i (r_res),
    .pop_i (pop && !empty),
    .res_o (out_res_o),
    .stat_o(rstat)
  );

  assign empty = (rstat.count == '0);

endmodule

// ----- hw/rtl/tpf_ram.sv -----
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ---------------------------------------------------------------------------
module tpf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/tpf_cmd_queue.sv -----
// ---------------------------------------------------------------------------
// Command queue
// Short queue of classified requests between the front and back ends.
// ---------------------------------------------------------------------------
module tpf_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tpf_pkg::job_t job_i,
  input  logic          pop_i,
  output tpf_pkg::job_t job_o,
  output tpf_pkg::qstat_t stat_o
);
  import tpf_pkg::*;

  job_t               entries_q [QDEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] count_q, count_d;
  logic               do_push, do_pop;

  assign do_push = push_i && (count_q != Q_CNT_W'(QDEPTH));
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o        = entries_q[rd_ptr_q];
  assign stat_o.count = count_q;

endmodule

// ----- hw/rtl/tpf_res_queue.sv -----
// ---------------------------------------------------------------------------
// Result queue
// Holds finished pixel results until the receiver takes them.
// ---------------------------------------------------------------------------
module tpf_res_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tpf_pkg::out_res_t res_i,
  input  logic              pop_i,
  output tpf_pkg::out_res_t res_o,
  output tpf_pkg::qstat_t   stat_o
);
  import tpf_pkg::*;

  out_res_t           entries_q [QDEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] count_q, count_d;
  logic               do_push, do_pop;

  assign do_push = push_i && (count_q != Q_CNT_W'(QDEPTH));
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= res_i;
    end
  end

  assign res_o        = entries_q[rd_ptr_q];
  assign stat_o.count = count_q;

endmodule

// ----- hw/rtl/tpf_front.sv -----
// ---------------------------------------------------------------------------
// Front end
// Accepts requests, owns the vertical scroll memory and latch, and queues
// the remaining work with the vertical scroll resolved.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tpf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tpf_pkg::cfg_t    cfg_i,
  input  logic             in_push_i,
  output logic             in_full_o,
  input  tpf_pkg::in_req_t in_req_i,
  input  tpf_pkg::qstat_t  qstat_i,
  output logic             q_push_o,
  output tpf_pkg::job_t    q_job_o
);
  import tpf_pkg::*;

  logic                accept;
  logic                is_win, is_b;
  logic                vs_we;
  logic [4:0]          vs_col;
  logic [6:0]          vs_idx;
  logic [VSRAM_AW-1:0] vs_addr;
  logic [VS_W-1:0]     vs_rdata;
  logic [VS_W-1:0]     vs_val;
  logic [Q_CNT_W:0]    occupancy;

  logic            s1_valid_q, s1_valid_d;
  in_req_t         s1_req_q;
  logic [VS_W-1:0] vlatch_q, vlatch_d;

  assign is_win = (cfg_i.plane_kind == PLANE_WIN);
  assign is_b   = (cfg_i.plane_kind == PLANE_B);
  assign accept = in_push_i && !in_full_o;

  assign occupancy = (Q_CNT_W+1)'(qstat_i.count) + (Q_CNT_W+1)'(s1_valid_q);
  assign in_full_o = occupancy >= (Q_CNT_W+1)'(QDEPTH);

  assign vs_we   = accept && (in_req_i.command == CMD_VSRAM_WR);
  assign vs_col  = cfg_i.vs_col ? in_req_i.pixel_x[8:4] : 5'd0;
  assign vs_idx  = {1'b0, vs_col, is_b};
  assign vs_addr = vs_we ? in_req_i.mem_address[VSRAM_AW-1:0] : vs_idx[VSRAM_AW-1:0];

  tpf_ram #(
    .Width(VS_W),
    .Depth(VSRAM_WORDS)
  ) u_vsram (
    .clk_i  (clk_i),
    .we_i   (vs_we),
    .addr_i (vs_addr),
    .wdata_i(in_req_i.mem_data[VS_W-1:0]),
    .rdata_o(vs_rdata)
  );

  assign s1_valid_d = accept && (in_req_i.command != CMD_VSRAM_WR);
  assign vs_val     = is_win ? vlatch_q : vs_rdata;

  always_comb begin
    vlatch_d = vlatch_q;
    if (s1_valid_q && (s1_req_q.command == CMD_PIXEL) && !is_win) begin
      vlatch_d = vs_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      vlatch_q   <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      vlatch_q   <= vlatch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q <= in_req_i;
    end
  end

  assign q_push_o        = s1_valid_q;
  assign q_job_o.cmd     = cmd_e'(s1_req_q.command);
  assign q_job_o.addr    = s1_req_q.mem_address;
  assign q_job_o.data    = s1_req_q.mem_data;
  assign q_job_o.x       = s1_req_q.pixel_x;
  assign q_job_o.y       = s1_req_q.line_y;
  assign q_job_o.fld     = s1_req_q.field_bit;
  assign q_job_o.vscroll = vs_val;

  `TPF_ASSERT_IMP(a_push_has_room, clk_i, rst_ni, q_push_o, qstat_i.count < Q_CNT_W'(QDEPTH))

endmodule

// ----- hw/rtl/tpf_back.sv -----
// ---------------------------------------------------------------------------
// Back end
// Sequences video memory writes, horizontal scroll loads and the two
// dependent reads of each pixel, then forms the colour result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tpf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tpf_pkg::cfg_t     cfg_i,
  input  tpf_pkg::job_t     q_job_i,
  input  tpf_pkg::qstat_t   qstat_i,
  output logic              q_pop_o,
  input  tpf_pkg::qstat_t   rstat_i,
  output logic              r_push_o,
  output tpf_pkg::out_res_t r_res_o
);
  import tpf_pkg::*;

  back_state_e state_q, state_d;

  logic               vr_we;
  logic [VRAM_AW-1:0] vr_addr;
  logic [DATA_W-1:0]  vr_rdata;

  logic is_win, is_b, il, wide, job_avail, room;
  logic [Q_CNT_W:0] pending;

  logic [8:0]        y_m;
  logic [ADDR_W-1:0] hs_addr;

  logic [9:0]        x_s, y_i;
  logic [10:0]       y_s;
  logic [1:0]        wsel, hsel;
  logic [6:0]        row_raw, row, col, w_m1, h_m1;
  logic [7:0]        w;
  logic [13:0]       cell_idx;
  logic [ADDR_W-1:0] nt_base, nt_addr;
  logic [2:0]        px_a;
  logic [3:0]        py_a;

  logic [ADDR_W-1:0] t0, t1, pat_addr;
  logic [2:0]        px_f;
  logic [3:0]        py_f;
  logic [3:0]        nib;

  logic              hs_load, b_load, c_load;
  logic [HS_W-1:0]   hscroll_q;
  logic [2:0]        b_px_q;
  logic [3:0]        b_py_q;
  logic              b_il_q;
  logic              c_valid_q;
  logic [1:0]        c_px_q, c_pal_q;
  logic              c_prio_q;

  tpf_ram #(
    .Width(DATA_W),
    .Depth(VRAM_WORDS)
  ) u_vram (
    .clk_i  (clk_i),
    .we_i   (vr_we),
    .addr_i (vr_addr),
    .wdata_i(q_job_i.data),
    .rdata_o(vr_rdata)
  );

  assign is_win    = (cfg_i.plane_kind == PLANE_WIN);
  assign is_b      = (cfg_i.plane_kind == PLANE_B);
  assign il        = cfg_i.disp_mode[1];
  assign wide      = cfg_i.disp_mode[0];
  assign job_avail = (qstat_i.count != '0);
  assign pending   = (Q_CNT_W+1)'(rstat_i.count) + (Q_CNT_W+1)'(c_valid_q);
  assign room      = pending < (Q_CNT_W+1)'(QDEPTH);

  always_comb begin
    case (cfg_i.hs_mode)
      HS_WHOLE: y_m = 9'd0;
      HS_EIGHT: y_m = q_job_i.y & 9'h007;
      HS_CELL:  y_m = q_job_i.y & 9'h1f8;
      HS_LINE:  y_m = q_job_i.y;
      default:  y_m = q_job_i.y;
    endcase
  end

  assign hs_addr = ADDR_W'(cfg_i.hs_base + ADDR_W'({y_m, 1'b0}) + ADDR_W'(is_b));

  assign x_s      = {1'b0, q_job_i.x} - hscroll_q;
  assign y_i      = il ? {q_job_i.y, q_job_i.fld} : {1'b0, q_job_i.y};
  assign y_s      = {1'b0, y_i} + q_job_i.vscroll;
  assign row_raw  = il ? y_s[10:4] : y_s[9:3];
  assign wsel     = is_win ? {1'b0, wide} : cfg_i.nt_size[1:0];
  assign hsel     = is_win ? 2'd0 : cfg_i.nt_size[3:2];
  assign w_m1     = {wsel, 5'h1f};
  assign h_m1     = {hsel, 5'h1f};
  assign w        = {3'({1'b0, wsel}) + 3'd1, 5'd0};
  assign row      = row_raw & h_m1;
  assign col      = x_s[9:3] & w_m1;
  assign cell_idx = 14'(row) * 14'(w) + 14'(col);
  assign nt_base  = (is_win && wide) ? (cfg_i.nt_base & ~NT_WIDE_CLR) : cfg_i.nt_base;
  assign nt_addr  = ADDR_W'(nt_base + ADDR_W'(cell_idx[11:0]));
  assign px_a     = x_s[2:0];
  assign py_a     = il ? y_s[3:0] : {1'b0, y_s[2:0]};

  assign t0       = b_il_q ? {vr_rdata[9:0], 5'd0} : {vr_rdata[10:0], 4'd0};
  assign px_f     = vr_rdata[11] ? (b_px_q ^ 3'd7) : b_px_q;
  assign py_f     = vr_rdata[12] ? (b_py_q ^ (b_il_q ? 4'hf : 4'h7)) : b_py_q;
  assign t1       = ADDR_W'(t0 + ADDR_W'({py_f, px_f[2]}));
  assign pat_addr = cfg_i.pat_base | t1;

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    vr_we   = 1'b0;
    vr_addr = q_job_i.addr[VRAM_AW-1:0];
    hs_load = 1'b0;
    b_load  = 1'b0;
    c_load  = 1'b0;
    case (state_q)
      ST_ISSUE: begin
        if (job_avail) begin
          case (q_job_i.cmd)
            CMD_VRAM_WR: begin
              q_pop_o = 1'b1;
              vr_we   = 1'b1;
            end
            CMD_LINE: begin
              q_pop_o = 1'b1;
              if (!is_win) begin
                vr_addr = hs_addr[VRAM_AW-1:0];
                state_d = ST_HSCROLL;
              end
            end
            CMD_PIXEL: begin
              if (room) begin
                q_pop_o = 1'b1;
                vr_addr = nt_addr[VRAM_AW-1:0];
                b_load  = 1'b1;
                state_d = ST_ATTR;
              end
            end
            default: begin
              q_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_HSCROLL: begin
        hs_load = 1'b1;
        state_d = ST_ISSUE;
      end
      ST_ATTR: begin
        vr_addr = pat_addr[VRAM_AW-1:0];
        c_load  = 1'b1;
        state_d = ST_ISSUE;
      end
      default: begin
        state_d = ST_ISSUE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_ISSUE;
      hscroll_q <= '0;
      c_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      c_valid_q <= c_load;
      if (hs_load) begin
        hscroll_q <= vr_rdata[HS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_load) begin
      b_px_q <= px_a;
      b_py_q <= py_a;
      b_il_q <= il;
    end
    if (c_load) begin
      c_px_q   <= px_f[1:0];
      c_pal_q  <= vr_rdata[14:13];
      c_prio_q <= vr_rdata[15];
    end
  end

  always_comb begin
    case (c_px_q)
      2'd0:    nib = vr_rdata[15:12];
      2'd1:    nib = vr_rdata[11:8];
      2'd2:    nib = vr_rdata[7:4];
      default: nib = vr_rdata[3:0];
    endcase
  end

  assign r_push_o             = c_valid_q;
  assign r_res_o.color_index  = (nib != 4'd0) ? {c_pal_q, nib} : 6'd0;
  assign r_res_o.priority_bit = c_prio_q;

  `TPF_ASSERT_NXT(a_pixel_to_attr, clk_i, rst_ni, q_pop_o && (q_job_i.cmd == CMD_PIXEL), state_q == ST_ATTR)
  `TPF_ASSERT_NXT(a_attr_to_result, clk_i, rst_ni, state_q == ST_ATTR, c_valid_q)
  `TPF_ASSERT_IMP(a_result_has_room, clk_i, rst_ni, r_push_o, rstat_i.count < Q_CNT_W'(QDEPTH))
  `TPF_ASSERT_IMP(a_no_pop_busy, clk_i, rst_ni, state_q != ST_ISSUE, !q_pop_o)

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tile plane pixel fetch testbench
// Drives write, line-start and pixel requests into the plane fetch block,
// predicts pixel results from a shadow copy of the memories, latches and
// registers (or takes them from the script), checks each result in order,
// and shapes random requests so that no memory entry is read unwritten.
// ---------------------------------------------------------------------------
module testbench;
  import tpf_pkg::*;

  localparam int unsigned CLK_HALF     = 10;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 195;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned LONG_HOLD    = 200;
  localparam longint      TIMEOUT_NS   = 64'd20_000_000;

  typedef struct packed {
    cmd_e        cmd;
    logic [14:0] addr;
    logic [15:0] data;
    logic [8:0]  x;
    logic [8:0]  y;
    logic        fld;
    logic        typed;
    logic [5:0]  color;
    logic        prio;
  } script_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  push = 1'b0;
  logic                  full;
  in_req_t               in_req_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  out_res_t              out_res_o;

  bit [15:0]       vram_q [VRAM_WORDS];
  bit              vram_ok [VRAM_WORDS];
  bit [VS_W-1:0]   vsram_q [VSRAM_WORDS];
  bit              vsram_ok [VSRAM_WORDS];
  bit [HS_W-1:0]   hs_latch_q = '0;
  bit [VS_W-1:0]   vs_latch_q = '0;
  cfg_t            cfg_q = '0;

  out_res_t        pending_pixels [$];
  int unsigned     errors = 0;
  int unsigned     sent_count = 0;
  int unsigned     line_count = 0;
  int unsigned     results_seen = 0;
  int unsigned     hold_request = 0;
  bit              calm = 1'b0;

  script_row_t script [21] = '{
    '{CMD_VSRAM_WR, 15'h0000, 16'h0000, 9'd0,   9'd0,   1'b0, 1'b0, 6'd0,  1'b0},
    '{CMD_VSRAM_WR, 15'h7fff, 16'hffff, 9'd0,   9'd0,   1'b0, 1'b0, 6'd0,  1'b0},
    '{CMD_VRAM_WR,  15'h0001, 16'he001, 9'd0,   9'd0,   1'b0, 1'b0, 6'd0,  1'b0},
    '{CMD_VRAM_WR,  15'h0010, 16'hf20a, 9'd0,   9'd0,   1'b0, 1'b0, 6'd0,  1'b0},
    '{CMD_VRAM_WR,  15'h0002, 16'h0801, 9'd0,   9'd0,   1'b0, 1'b0, 6'd0,  1'b0},
    '{CMD_VRAM_WR,  15'h0011, 16'h0005, 9'd0,   9'd0,   1'b0, 1'b0, 6'd0,  1'b0},
    '{CMD_VRAM_WR,  15'h0003, 16'h1001, 9'd0,   9'd0,   1'b0, 1'b0, 6'd0,  1'b0},
    '{CMD_VRAM_WR,  15'h001e, 16'h9000, 9'd0,   9'd0,   1'b0, 1'b0, 6'd0,  1'b0},
    '{CMD_PIXEL,    15'h0000, 16'h0000, 9'd8,   9'd0,   1'b0, 1'b1, 6'h3f, 1'b1},
    '{CMD_PIXEL,    15'h0000, 16'h0000, 9'd9,   9'd0,   1'b0, 1'b1, 6'h32, 1'b1},
    '{CMD_PIXEL,    15'h0000, 16'h0000, 9'd10,  9'd0,   1'b0, 1'b1, 6'h00, 1'b1},
    '{CMD_PIXEL,    15'h0000, 16'h0000, 9'd11,  9'd0,   1'b0, 1'b1, 6'h3a, 1'b1},
    '{CMD_PIXEL,    15'h0000, 16'h0000, 9'd16,  9'd0,   1'b0, 1'b1, 6'h05, 1'b0},
    '{CMD_PIXEL,    15'h0000, 16'h0000, 9'd24,  9'd0,   1'b0, 1'b1, 6'h09, 1'b0},
    '{CMD_VRAM_WR,  15'h0000, 16'hfff8, 9'd0,   9'd0,   1'b0, 1'b0, 6'd0,  1'b0},
    '{CMD_LINE,     15'h0000, 16'h0000, 9'd0,   9'd0,   1'b0, 1'b0, 6'd0,  1'b0},
    '{CMD_PIXEL,    15'h0000, 16'h0000, 9'd0,   9'd0,   1'b0, 1'b1, 6'h3f, 1'b1},
    '{CMD_VRAM_WR,  15'h03e0, 16'h6002, 9'd0,   9'd0,   1'b0, 1'b0, 6'd0,  1'b0},
    '{CMD_VRAM_WR,  15'h002f, 16'h000c, 9'd0,   9'd0,   1'b0, 1'b0, 6'd0,  1'b0},
    '{CMD_PIXEL,    15'h0000, 16'h0000, 9'd511, 9'd511, 1'b1, 1'b0, 6'd0,  1'b0},
    '{CMD_VRAM_WR,  15'h7fff, 16'h0000, 9'd0,   9'd0,   1'b0, 1'b0, 6'd0,  1'b0}
  };

  tile_plane_pixel_fetch_top DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .push,
    .full,
    .in_req_i,
    .empty,
    .pop,
    .out_res_o
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic bit is_window();
    return cfg_q.plane_kind == PLANE_WIN;
  endfunction

  function automatic int unsigned plane_b_offset();
    return (cfg_q.plane_kind == PLANE_B) ? 1 : 0;
  endfunction

  function automatic int unsigned hscroll_addr(input logic [8:0] line);
    int unsigned mask;
    case (cfg_q.hs_mode)
      HS_WHOLE: mask = 32'd0;
      HS_EIGHT: mask = 32'd7;
      HS_CELL:  mask = ~32'd7;
      default:  mask = ~32'd0;
    endcase
    return ((cfg_q.hs_base + ((32'(line) & mask) << 1) + plane_b_offset()) & 32'h7fff)
           % VRAM_WORDS;
  endfunction

  function automatic void trace_pixel(input in_req_t r, output int unsigned vs_a,
                                      output int unsigned nt_a, output int unsigned pat_a,
                                      output logic [VS_W-1:0] vs_val, output out_res_t res);
    int unsigned col, il, x, y, w, h, base, px, py, attr, taddr, word, color;
    col = cfg_q.vs_col ? (32'(r.pixel_x) >> 4) : 0;
    vs_a = (((col << 1) + plane_b_offset()) & 32'h7f) % VSRAM_WORDS;
    vs_val = is_window() ? vs_latch_q : vsram_q[vs_a];
    il = cfg_q.disp_mode[1];
    x = r.pixel_x;
    y = r.line_y;
    if (il != 0) y = (y << 1) | r.field_bit;
    x = x - hs_latch_q;
    y = y + vs_val;
    if (is_window()) begin
      w = cfg_q.disp_mode[0] ? 64 : 32;
      h = 32;
    end else begin
      w = 32 * (1 + cfg_q.nt_size[1:0]);
      h = 32 * (1 + cfg_q.nt_size[3:2]);
    end
    base = cfg_q.nt_base;
    if (is_window() && cfg_q.disp_mode[0]) base &= ~32'(NT_WIDE_CLR);
    nt_a = ((base + ((((y >> (3 + il)) & (h - 1)) * w + ((x >> 3) & (w - 1))) & 32'h0fff))
            & 32'h7fff) % VRAM_WORDS;
    attr = vram_q[nt_a];
    px = x & 7;
    py = y & (7 + il * 8);
    taddr = ((attr & 32'h7ff) << (4 + il)) & 32'h7fff;
    if (attr[11]) px ^= 7;
    if (attr[12]) py ^= 7 + il * 8;
    taddr = (taddr + ((py << 1) | (px >> 2))) & 32'h7fff;
    pat_a = ((cfg_q.pat_base | taddr) & 32'h7fff) % VRAM_WORDS;
    word = vram_q[pat_a];
    color = (word >> (((px & 3) ^ 3) << 2)) & 15;
    res.color_index = (color != 0) ? 6'((((attr >> 13) & 3) << 4) | color) : 6'd0;
    res.priority_bit = attr[15];
  endfunction

  function automatic void apply_request(input in_req_t r, output bit made, output out_res_t res);
    int unsigned vs_a, nt_a, pat_a, a;
    logic [VS_W-1:0] vs_val;
    made = 1'b0;
    res = '0;
    case (cmd_e'(r.command))
      CMD_VRAM_WR: begin
        a = r.mem_address % VRAM_WORDS;
        vram_q[a] = r.mem_data;
        vram_ok[a] = 1'b1;
      end
      CMD_VSRAM_WR: begin
        a = r.mem_address % VSRAM_WORDS;
        vsram_q[a] = r.mem_data[VS_W-1:0];
        vsram_ok[a] = 1'b1;
      end
      CMD_LINE: begin
        if (!is_window()) begin
          a = hscroll_addr(r.line_y);
          hs_latch_q = vram_q[a][HS_W-1:0];
        end
      end
      default: begin
        trace_pixel(r, vs_a, nt_a, pat_a, vs_val, res);
        if (!is_window()) vs_latch_q = vs_val;
        made = 1'b1;
      end
    endcase
  endfunction

  function automatic in_req_t random_req();
    in_req_t r;
    r.command = 2'($urandom_range(0, 3));
    r.mem_address = 15'($urandom_range(0, 32767));
    r.mem_data = 16'($urandom_range(0, 65535));
    r.pixel_x = 9'($urandom_range(0, 511));
    r.line_y = 9'($urandom_range(0, 511));
    r.field_bit = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic send_req(input in_req_t r, input bit typed = 1'b0,
                          input out_res_t typed_res = '0);
    bit made;
    out_res_t res;
    push <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (full);
    apply_request(r, made, res);
    if (made) pending_pixels.push_back(typed ? typed_res : res);
    if (r.command == CMD_LINE) line_count++;
    sent_count++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic send_line(input in_req_t r);
    in_req_t w;
    int unsigned a;
    a = hscroll_addr(r.line_y);
    if (!is_window() && !vram_ok[a]) begin
      w = random_req();
      w.command = CMD_VRAM_WR;
      w.mem_address = 15'(a);
      send_req(w);
    end
    send_req(r);
  endtask

  task automatic send_pixel(input in_req_t r);
    in_req_t w;
    int unsigned vs_a, nt_a, pat_a;
    logic [VS_W-1:0] vs_val;
    out_res_t res;
    forever begin
      trace_pixel(r, vs_a, nt_a, pat_a, vs_val, res);
      w = random_req();
      if (!is_window() && !vsram_ok[vs_a]) begin
        w.command = CMD_VSRAM_WR;
        w.mem_address = 15'(($urandom & ~(VSRAM_WORDS - 1)) | vs_a);
      end else if (!vram_ok[nt_a]) begin
        w.command = CMD_VRAM_WR;
        w.mem_address = 15'(nt_a);
      end else if (!vram_ok[pat_a]) begin
        w.command = CMD_VRAM_WR;
        w.mem_address = 15'(pat_a);
      end else begin
        break;
      end
      send_req(w);
    end
    send_req(r);
  endtask

  task automatic scan_line();
    in_req_t r;
    in_req_t w;
    int unsigned n;
    r = random_req();
    r.command = CMD_LINE;
    send_line(r);
    n = $urandom_range(2, 12);
    r.command = CMD_PIXEL;
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        w = random_req();
        w.command = CMD_VRAM_WR;
        send_req(w);
      end
      send_pixel(r);
      r.pixel_x = r.pixel_x + 9'($urandom_range(1, 4));
    end
  endtask

  task automatic random_sequence();
    in_req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r = random_req();
    if (pick < 60) begin
      scan_line();
    end else if (pick < 80) begin
      r.command = CMD_PIXEL;
      send_pixel(r);
    end else if (pick < 90) begin
      r.command = CMD_VRAM_WR;
      send_req(r);
    end else if (pick < 95) begin
      r.command = CMD_VSRAM_WR;
      send_req(r);
    end else begin
      r.command = CMD_LINE;
      send_line(r);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
  endtask

  task automatic program_config(input cfg_t c);
    write_reg(CFG_PLANE_KIND, c.plane_kind);
    write_reg(CFG_HS_BASE, c.hs_base);
    write_reg(CFG_HS_MODE, c.hs_mode);
    write_reg(CFG_VS_COL, c.vs_col);
    write_reg(CFG_NT_BASE, c.nt_base);
    write_reg(CFG_NT_SIZE, c.nt_size);
    write_reg(CFG_PAT_BASE, c.pat_base);
    write_reg(CFG_DISP_MODE, c.disp_mode);
    cfg_we_i <= 1'b0;
    cfg_q = c;
  endtask

  function automatic cfg_t pick_config(input int unsigned phase);
    cfg_t c;
    c.plane_kind = 2'($urandom_range(0, 3));
    c.hs_base = 15'($urandom_range(0, 32767));
    c.hs_mode = 2'($urandom_range(0, 3));
    c.vs_col = 1'($urandom_range(0, 1));
    c.nt_base = 15'($urandom_range(0, 32767));
    c.nt_size = 4'($urandom_range(0, 15));
    c.pat_base = 15'($urandom_range(0, 32767));
    c.disp_mode = 2'($urandom_range(0, 3));
    case (phase)
      0: c = '0;
      1: c = '1;
      2: begin
        c.plane_kind = PLANE_WIN;
        c.disp_mode[0] = 1'b1;
      end
      6: begin
        c.plane_kind = PLANE_WIN;
        c.disp_mode[0] = 1'b0;
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic settle();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : result_side
    out_res_t want;
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected result, expected none, got color %0d priority %0d",
                   $time, out_res_o.color_index, out_res_o.priority_bit);
          errors++;
        end else begin
          want = pending_pixels.pop_front();
          results_seen++;
          if (out_res_o.color_index !== want.color_index) begin
            $display("%0t: color_index expected %0d, got %0d", $time, want.color_index,
                     out_res_o.color_index);
            errors++;
          end
          if (out_res_o.priority_bit !== want.priority_bit) begin
            $display("%0t: priority_bit expected %0d, got %0d", $time, want.priority_bit,
                     out_res_o.priority_bit);
            errors++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (hold_request > 0) begin
        stall = hold_request - 1;
        hold_request = 0;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 7);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : request_side
    in_req_t r;
    out_res_t res;
    int unsigned start;
    bit paused;
    paused = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      r = '0;
      r.command = script[i].cmd;
      r.mem_address = script[i].addr;
      r.mem_data = script[i].data;
      r.pixel_x = script[i].x;
      r.line_y = script[i].y;
      r.field_bit = script[i].fld;
      res.color_index = script[i].color;
      res.priority_bit = script[i].prio;
      send_req(r, script[i].typed, res);
    end

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      settle();
      program_config(pick_config(phase));
      calm = (phase == PHASES - 1);
      if (phase == 3) hold_request = LONG_HOLD;
      start = sent_count;
      while (sent_count - start < PHASE_ITEMS) begin
        if (phase == 5 && !paused && sent_count - start > PHASE_ITEMS / 2) begin
          paused = 1'b1;
          push <= 1'b0;
          do @(posedge clk_i); while (pending_pixels.size() != 0);
        end
        random_sequence();
      end
    end
    settle();

    $display("Sent %0d requests over %0d register settings: %0d line starts, %0d pixels checked.",
             sent_count, PHASES, line_count, results_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timed out waiting for the block.");
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/tpf_pkg.sv
hw/rtl/tpf_ram.sv
hw/rtl/tpf_cmd_queue.sv
hw/rtl/tpf_res_queue.sv
hw/rtl/tpf_front.sv
hw/rtl/tpf_back.sv
hw/rtl/tile_plane_pixel_fetch_top.sv
tb/testbench.sv
